// ----- rtl/rrcp_pkg.sv -----
// Package for the rotated rectangle circle push-out unit: widths, sine polynomial coefficients, helpers.
`default_nettype none
package rrcp_pkg;

  localparam int CoordW    = 32;
  localparam int RadiusW   = 31;
  localparam int AngleW    = 16;
  localparam int AngleBits = 16;  // top phase bits kept, 8 to 24
  localparam int TrigW     = 32;  // signed Q2.30, range +-2^30
  localparam int WideW     = 36;  // frame coordinates before saturation
  localparam int ProdW     = WideW + TrigW;

  localparam logic [30:0] Q30One = 31'h4000_0000;

  // Horner coefficients of the quarter-turn sine polynomial
  localparam logic [31:0] SinCoef0 = 32'd1686629713;
  localparam logic [31:0] SinCoef1 = 32'd693598668;
  localparam logic [31:0] SinCoef2 = 32'd85569306;
  localparam logic [31:0] SinCoef3 = 32'd5026995;
  localparam logic [31:0] SinCoef4 = 32'd172272;
  localparam logic [31:0] SinCoef5 = 32'd3864;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic signed [TrigW-1:0]  trig_t;

  // Q2.30 unsigned product truncated by 30
  function automatic logic [31:0] mulq30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[61:30];
  endfunction

  // Saturate a wide value to 32 bit signed
  function automatic coord_t sat32(input logic signed [WideW+1:0] v);
    logic signed [WideW+1:0] mx;
    logic signed [WideW+1:0] mn;
    mx = (WideW+2)'(32'sh7FFF_FFFF);
    mn = -(WideW+2)'(64'sh8000_0000);
    if (v > mx) return coord_t'(32'sh7FFF_FFFF);
    if (v < mn) return coord_t'(32'sh8000_0000);
    return v[CoordW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rrcp_if.sv -----
// Valid/ready channel interface carrying a request payload.
`default_nettype none
interface rrcp_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rotated_rect_circle_pushout_unit.sv -----
// Top level: circle versus rotated rectangle push-out pipeline.
// Pipeline of 14 register stages, the last of them the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Sine polynomial is one multiplier per stage; each rotation is a product stage then a sum stage.
// Reset: synchronous rst clears all stage valid bits; payload registers are not reset.
`default_nettype none
module rotated_rect_circle_pushout_unit
  import rrcp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rrcp_if.sink   in_req,
  rrcp_if.source out_res
);

  localparam int NStg = 14;

  // pipeline payload carried through every stage
  typedef struct packed {
    coord_t mnx, mny, mxx, mxy, pvx, pvy;
    logic [RadiusW-1:0] r;
    wide_t dx, dy;           // circle offset, later push-out offset
    logic [31:0] xs, xc;     // folded sine / cosine arguments
    logic [31:0] zs, zc;     // squares
    logic [31:0] as, ac;     // Horner accumulators
    logic ns, nc;            // negate flags
    trig_t s, c;
    logic signed [ProdW:0] p0, p1, p2, p3;
    wide_t lx, ly;
    logic hitf;
  } stage_t;

  stage_t st [NStg-1];
  logic   vld [NStg-1];
  logic   adv;

  assign adv = !out_res.valid || out_res.ready;
  assign in_req.ready = adv;

  // phase and quadrant folding
  logic [31:0] ph, phc;
  logic [31:0] keep;
  assign keep = ~((32'd1 << (32 - AngleBits)) - 32'd1);
  assign ph  = {in_req.data.angle, 16'd0} & keep;
  assign phc = ph + 32'h4000_0000;

  function automatic logic [31:0] fold(input logic [31:0] p);
    logic [31:0] f;
    f = {2'b00, p[29:0]};
    if (p[30]) f = {1'b0, Q30One} - f;
    return f;
  endfunction

  // rotation helper: floor((a + 2^29) / 2^30)
  function automatic wide_t rnd30(input logic signed [ProdW:0] a);
    logic signed [ProdW:0] t;
    t = a + (ProdW+1)'(64'sd536870912);
    return t[WideW+29:30];
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return v[WideW-1] ? -v : v;
  endfunction

  stage_t nx [NStg-1];
  always_comb begin
    nx[0] = '0;
    for (int i = 1; i < NStg - 1; i++) nx[i] = st[i-1];
    // stage 0: capture, offsets, fold, squares
    nx[0].mnx = in_req.data.rect_min_x; nx[0].mny = in_req.data.rect_min_y;
    nx[0].mxx = in_req.data.rect_max_x; nx[0].mxy = in_req.data.rect_max_y;
    nx[0].pvx = in_req.data.pivot_x;    nx[0].pvy = in_req.data.pivot_y;
    nx[0].r   = in_req.data.circle_radius;
    nx[0].dx  = WideW'(in_req.data.circle_x) - WideW'(in_req.data.pivot_x);
    nx[0].dy  = WideW'(in_req.data.circle_y) - WideW'(in_req.data.pivot_y);
    nx[0].xs  = fold(ph);  nx[0].ns = ph[31];
    nx[0].xc  = fold(phc); nx[0].nc = phc[31];
    nx[0].zs  = mulq30(nx[0].xs, nx[0].xs);
    nx[0].zc  = mulq30(nx[0].xc, nx[0].xc);
    // stage 1: first Horner step
    nx[1].as = SinCoef4 - mulq30(SinCoef5, st[0].zs);
    nx[1].ac = SinCoef4 - mulq30(SinCoef5, st[0].zc);
    // stages 2..5: Horner steps
    nx[2].as = SinCoef3 - mulq30(st[1].as, st[1].zs);
    nx[2].ac = SinCoef3 - mulq30(st[1].ac, st[1].zc);
    nx[3].as = SinCoef2 - mulq30(st[2].as, st[2].zs);
    nx[3].ac = SinCoef2 - mulq30(st[2].ac, st[2].zc);
    nx[4].as = SinCoef1 - mulq30(st[3].as, st[3].zs);
    nx[4].ac = SinCoef1 - mulq30(st[3].ac, st[3].zc);
    nx[5].as = SinCoef0 - mulq30(st[4].as, st[4].zs);
    nx[5].ac = SinCoef0 - mulq30(st[4].ac, st[4].zc);
    // stage 6: final multiply, clamp, sign
    begin
      logic [31:0] vs, vc;
      vs = mulq30(st[5].as, st[5].xs);
      vc = mulq30(st[5].ac, st[5].xc);
      if (vs > {1'b0, Q30One}) vs = {1'b0, Q30One};
      if (vc > {1'b0, Q30One}) vc = {1'b0, Q30One};
      nx[6].s = st[5].ns ? -trig_t'(vs) : trig_t'(vs);
      nx[6].c = st[5].nc ? -trig_t'(vc) : trig_t'(vc);
    end
    // stage 7: inverse rotation products
    nx[7].p0 = (ProdW+1)'(st[6].dx) * (ProdW+1)'(st[6].c);
    nx[7].p1 = (ProdW+1)'(st[6].dy) * (ProdW+1)'(st[6].s);
    nx[7].p2 = (ProdW+1)'(st[6].dy) * (ProdW+1)'(st[6].c);
    nx[7].p3 = (ProdW+1)'(st[6].dx) * (ProdW+1)'(st[6].s);
    // stage 8: local coordinates
    nx[8].lx = WideW'(st[7].pvx) + rnd30(st[7].p0 + st[7].p1);
    nx[8].ly = WideW'(st[7].pvy) + rnd30(st[7].p2 - st[7].p3);
    // stage 9: overlap test and nearest wall
    begin
      wide_t r, mnx, mny, mxx, mxy, lx, ly, best, d, px, py;
      r = WideW'({1'b0, st[8].r});
      mnx = WideW'(st[8].mnx); mny = WideW'(st[8].mny);
      mxx = WideW'(st[8].mxx); mxy = WideW'(st[8].mxy);
      lx = st[8].lx; ly = st[8].ly;
      nx[9].hitf = !(lx + r < mnx || lx - r > mxx || ly + r < mny || ly - r > mxy);
      best = wabs(lx - mnx); px = mnx - r; py = ly;
      d = wabs(lx - mxx);
      if (d < best) begin best = d; px = mxx + r; py = ly; end
      d = wabs(ly - mny);
      if (d < best) begin best = d; px = lx; py = mny - r; end
      d = wabs(ly - mxy);
      if (d < best) begin best = d; px = lx; py = mxy + r; end
      nx[9].dx = px - WideW'(st[8].pvx);
      nx[9].dy = py - WideW'(st[8].pvy);
    end
    // stage 10: forward rotation products
    nx[10].p0 = (ProdW+1)'(st[9].dx) * (ProdW+1)'(st[9].c);
    nx[10].p1 = (ProdW+1)'(st[9].dy) * (ProdW+1)'(st[9].s);
    nx[10].p2 = (ProdW+1)'(st[9].dy) * (ProdW+1)'(st[9].c);
    nx[10].p3 = (ProdW+1)'(st[9].dx) * (ProdW+1)'(st[9].s);
    // stage 11: world offsets
    nx[11].lx = rnd30(st[10].p0 - st[10].p1);
    nx[11].ly = rnd30(st[10].p2 + st[10].p3);
    // stage 12: add pivot (kept wide)
    nx[12].lx = st[11].lx + WideW'(st[11].pvx);
    nx[12].ly = st[11].ly + WideW'(st[11].pvy);
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NStg - 1; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_req.valid;
      for (int i = 1; i < NStg - 1; i++) vld[i] <= vld[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) for (int i = 0; i < NStg - 1; i++) st[i] <= nx[i];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_res.valid <= 1'b0;
    end else if (adv) begin
      out_res.valid <= vld[NStg-2];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.data.hit <= st[NStg-2].hitf;
      out_res.data.resolve_x <= st[NStg-2].hitf ?
          sat32((WideW+2)'(st[NStg-2].lx)) : '0;
      out_res.data.resolve_y <= st[NStg-2].hitf ?
          sat32((WideW+2)'(st[NStg-2].ly)) : '0;
    end
  end

  // a stalled result holds in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.data))
    else $error("result changed under stall");
  // a miss gives zero position
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && !out_res.data.hit |->
      out_res.data.resolve_x == '0 && out_res.data.resolve_y == '0)
    else $error("miss with non-zero position");
  // ready follows the output register
  a_rdy: assert property (@(posedge clk) in_req.ready == (!out_res.valid || out_res.ready))
    else $error("ready mismatch");

endmodule
`default_nettype wire
